>>> rtl/owd_pkg.sv
package owd_pkg;

  localparam int MAX_FACTOR = 64;
  localparam int AW         = $clog2(MAX_FACTOR);
  localparam int NW         = $clog2(MAX_FACTOR + 1);
  localparam int SMP_W      = 32;
  localparam int CFG_W      = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;
  localparam int FRAC       = 16;
  localparam int SUM_W      = SMP_W + AW;
  localparam int DD_W       = SUM_W + FRAC;
  localparam int DW         = 51;
  localparam int D2W        = 49;
  localparam int MW         = D2W + SMP_W;
  localparam int PPW        = MW + D2W;
  localparam int PWW        = 2 * D2W;
  localparam int PW         = PPW + AW + 2;
  localparam int CNT_W      = 7;
  localparam int P_MIN      = 42950;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_AQ,
    S_RD,
    S_D1,
    S_D2,
    S_MM,
    S_MPW,
    S_ACC,
    S_CHK,
    S_QD,
    S_OUT
  } state_t;

endpackage

>>> rtl/owd_in_if.sv
interface owd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [owd_pkg::SMP_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

>>> rtl/owd_out_if.sv
interface owd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [owd_pkg::SMP_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

>>> rtl/owd_ram.sv
module owd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/outlier_weighted_decimator.sv
// Outlier-weighted decimator. Samples are taken one per cycle while the block is idle; when
// the last sample of a block of n arrives the block stops accepting and works out the result:
// a bit-serial division for the mean, then for each stored sample a memory read, two
// difference steps, two shift-add multipliers and one accumulate, then a check, a bit-serial
// quotient unless the mean is kept, and a load of the output register. The result waits in
// an output register, so the next block's samples are taken while it is still unread.
module outlier_weighted_decimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [owd_pkg::CFG_W-1:0]     cfg_wdata,
  owd_in_if.sink                        in_chan,
  owd_out_if.source                     out_chan
);

  owd_pkg::state_t state_r, state_nxt;

  logic [owd_pkg::CFG_W-1:0]        cfg_r;
  logic [owd_pkg::NW-1:0]           fill_r, fill_nxt;
  logic signed [owd_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [owd_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [owd_pkg::NW-1:0]           idx_r, idx_nxt;
  logic                             neg_r, neg_nxt;
  logic [owd_pkg::DD_W-1:0]         dd_r, dd_nxt;
  logic [owd_pkg::NW-1:0]           rem_r, rem_nxt;
  logic signed [owd_pkg::DW-1:0]    aq_r, aq_nxt;
  logic signed [owd_pkg::SMP_W-1:0] x_r, x_nxt;
  logic [owd_pkg::D2W-1:0]          d1_r, d1_nxt;
  logic [owd_pkg::D2W-1:0]          d2_r, d2_nxt;
  logic [owd_pkg::MW-1:0]           pm_r, pm_nxt;
  logic [owd_pkg::PPW-1:0]          pp_r, pp_nxt;
  logic [owd_pkg::PWW-1:0]          pw_r, pw_nxt;
  logic signed [owd_pkg::PW-1:0]    p_r, p_nxt;
  logic [owd_pkg::PW-1:0]           w_r, w_nxt;
  logic [owd_pkg::SMP_W-1:0]        q_r, q_nxt;
  logic [owd_pkg::SMP_W-1:0]        res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [owd_pkg::SMP_W-1:0]        out_data_r, out_data_nxt;

  logic [owd_pkg::NW-1:0]    n_eff;
  logic                      in_beat;
  logic                      last_beat;
  logic                      out_load;
  logic                      ram_we;
  logic [owd_pkg::AW-1:0]    ram_raddr;
  logic [owd_pkg::SMP_W-1:0] ram_rdata;

  logic signed [owd_pkg::SUM_W-1:0] acc_sum;
  logic [owd_pkg::SUM_W-1:0]        acc_mag;
  logic [owd_pkg::NW:0]             div_t;
  logic                             div_ge;
  logic signed [owd_pkg::DW-1:0]    xs;
  logic signed [owd_pkg::DW-1:0]    diff1;
  logic signed [owd_pkg::DW-1:0]    diff2;
  logic [owd_pkg::D2W-1:0]          d2v;
  logic [owd_pkg::SMP_W-1:0]        absx;
  logic [owd_pkg::D2W:0]            mm_hi;
  logic [owd_pkg::MW:0]             pp_hi;
  logic [owd_pkg::D2W:0]            pw_hi;
  logic signed [owd_pkg::PW-1:0]    pp_ext;
  logic signed [owd_pkg::DW-1:0]    aq_trunc;
  logic                             q_ge;
  logic                             keep_mean;

  // Out-of-range factors are clamped: zero acts as one, large values as the store depth.
  always_comb begin
    logic [31:0] c32;
    c32 = 32'(cfg_r);
    if (c32 == 32'd0) begin
      n_eff = owd_pkg::NW'(1);
    end else if (c32 > 32'(owd_pkg::MAX_FACTOR)) begin
      n_eff = owd_pkg::NW'(owd_pkg::MAX_FACTOR);
    end else begin
      n_eff = owd_pkg::NW'(c32);
    end
  end

  assign in_beat   = in_chan.valid && in_chan.ready;
  assign last_beat = (fill_r + owd_pkg::NW'(1)) == n_eff;
  assign out_load  = (state_r == owd_pkg::S_OUT) && (!out_valid_r || out_chan.ready);

  owd_ram #(
    .WIDTH (owd_pkg::SMP_W),
    .DEPTH (owd_pkg::MAX_FACTOR)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[owd_pkg::AW-1:0]),
    .wdata (in_chan.sample_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      owd_pkg::S_IDLE: begin
        if (in_beat && last_beat && !cfg_we) begin
          state_nxt = owd_pkg::S_DIV;
        end
      end
      owd_pkg::S_DIV: begin
        if (cnt_r == owd_pkg::CNT_W'(owd_pkg::DD_W - 1)) begin
          state_nxt = owd_pkg::S_AQ;
        end
      end
      owd_pkg::S_AQ:  state_nxt = owd_pkg::S_RD;
      owd_pkg::S_RD:  state_nxt = owd_pkg::S_D1;
      owd_pkg::S_D1:  state_nxt = owd_pkg::S_D2;
      owd_pkg::S_D2:  state_nxt = owd_pkg::S_MM;
      owd_pkg::S_MM: begin
        if (cnt_r == owd_pkg::CNT_W'(owd_pkg::SMP_W - 1)) begin
          state_nxt = owd_pkg::S_MPW;
        end
      end
      owd_pkg::S_MPW: begin
        if (cnt_r == owd_pkg::CNT_W'(owd_pkg::D2W - 1)) begin
          state_nxt = owd_pkg::S_ACC;
        end
      end
      owd_pkg::S_ACC: begin
        if ((idx_r + owd_pkg::NW'(1)) == n_eff) begin
          state_nxt = owd_pkg::S_CHK;
        end else begin
          state_nxt = owd_pkg::S_RD;
        end
      end
      owd_pkg::S_CHK: begin
        if (keep_mean) begin
          state_nxt = owd_pkg::S_OUT;
        end else begin
          state_nxt = owd_pkg::S_QD;
        end
      end
      owd_pkg::S_QD: begin
        if (cnt_r == owd_pkg::CNT_W'(owd_pkg::SMP_W - 1)) begin
          state_nxt = owd_pkg::S_OUT;
        end
      end
      owd_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = owd_pkg::S_IDLE;
        end
      end
      default: state_nxt = owd_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_chan.ready = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = idx_r[owd_pkg::AW-1:0];
    case (state_r)
      owd_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        ram_we        = in_beat;
      end
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  // Arithmetic shared by the datapath.
  always_comb begin
    acc_sum  = sum_r + owd_pkg::SUM_W'(in_chan.sample_in);
    acc_mag  = acc_sum[owd_pkg::SUM_W-1] ? owd_pkg::SUM_W'(-acc_sum) : owd_pkg::SUM_W'(acc_sum);
    div_t    = {rem_r, dd_r[owd_pkg::DD_W-1]};
    div_ge   = div_t >= {1'b0, n_eff};
    xs       = owd_pkg::DW'($signed({ram_rdata, {owd_pkg::FRAC{1'b0}}}));
    diff1    = xs - aq_r;
    diff2    = $signed({{(owd_pkg::DW - owd_pkg::D2W){1'b0}}, d1_r}) - aq_r;
    d2v      = diff2[owd_pkg::DW-1] ? owd_pkg::D2W'(-diff2) : owd_pkg::D2W'(diff2);
    absx     = x_r[owd_pkg::SMP_W-1] ? owd_pkg::SMP_W'(-x_r) : owd_pkg::SMP_W'(x_r);
    mm_hi    = {1'b0, pm_r[owd_pkg::MW-1:owd_pkg::SMP_W]} + (pm_r[0] ? {1'b0, d2_r} : '0);
    pp_hi    = {1'b0, pp_r[owd_pkg::PPW-1:owd_pkg::D2W]} + (pp_r[0] ? {1'b0, pm_r} : '0);
    pw_hi    = {1'b0, pw_r[owd_pkg::PWW-1:owd_pkg::D2W]} + (pw_r[0] ? {1'b0, d2_r} : '0);
    pp_ext   = $signed({{(owd_pkg::PW - owd_pkg::PPW){1'b0}}, pp_r});
    aq_trunc = (aq_r + (aq_r[owd_pkg::DW-1] ? owd_pkg::DW'((1 << owd_pkg::FRAC) - 1) : '0))
               >>> owd_pkg::FRAC;
    q_ge     = $unsigned(p_r) >= w_r;
    keep_mean = p_r[owd_pkg::PW-1] || (p_r < owd_pkg::PW'(owd_pkg::P_MIN));
  end

  // Datapath next values.
  always_comb begin
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    dd_nxt        = dd_r;
    rem_nxt       = rem_r;
    aq_nxt        = aq_r;
    x_nxt         = x_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    pm_nxt        = pm_r;
    pp_nxt        = pp_r;
    pw_nxt        = pw_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    q_nxt         = q_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      owd_pkg::S_IDLE: begin
        if (in_beat) begin
          if (last_beat) begin
            fill_nxt = '0;
            sum_nxt  = '0;
            neg_nxt  = acc_sum[owd_pkg::SUM_W-1];
            dd_nxt   = {acc_mag, {owd_pkg::FRAC{1'b0}}};
            rem_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            fill_nxt = fill_r + owd_pkg::NW'(1);
            sum_nxt  = acc_sum;
          end
        end
      end
      owd_pkg::S_DIV: begin
        // One quotient bit of the scaled block sum over n per cycle.
        rem_nxt = div_ge ? owd_pkg::NW'(div_t - {1'b0, n_eff}) : owd_pkg::NW'(div_t);
        dd_nxt  = {dd_r[owd_pkg::DD_W-2:0], div_ge};
        cnt_nxt = cnt_r + owd_pkg::CNT_W'(1);
      end
      owd_pkg::S_AQ: begin
        aq_nxt = neg_r ? -owd_pkg::DW'(dd_r) : owd_pkg::DW'(dd_r);
        p_nxt  = owd_pkg::PW'(aq_nxt) <<< owd_pkg::FRAC;
        w_nxt  = owd_pkg::PW'(1) << owd_pkg::SMP_W;
        idx_nxt = '0;
      end
      owd_pkg::S_D1: begin
        x_nxt  = $signed(ram_rdata);
        d1_nxt = diff1[owd_pkg::DW-1] ? owd_pkg::D2W'(-diff1) : owd_pkg::D2W'(diff1);
      end
      owd_pkg::S_D2: begin
        d2_nxt  = d2v;
        pm_nxt  = {{owd_pkg::D2W{1'b0}}, absx};
        pp_nxt  = {{owd_pkg::MW{1'b0}}, d2v};
        pw_nxt  = {{owd_pkg::D2W{1'b0}}, d2v};
        cnt_nxt = '0;
      end
      owd_pkg::S_MM: begin
        pm_nxt = {mm_hi, pm_r[owd_pkg::SMP_W-1:1]};
        if (cnt_r == owd_pkg::CNT_W'(owd_pkg::SMP_W - 1)) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + owd_pkg::CNT_W'(1);
        end
      end
      owd_pkg::S_MPW: begin
        // Both products take the bits of the same multiplier, low bit first.
        pp_nxt  = {pp_hi, pp_r[owd_pkg::D2W-1:1]};
        pw_nxt  = {pw_hi, pw_r[owd_pkg::D2W-1:1]};
        cnt_nxt = cnt_r + owd_pkg::CNT_W'(1);
      end
      owd_pkg::S_ACC: begin
        p_nxt   = x_r[owd_pkg::SMP_W-1] ? p_r - pp_ext : p_r + pp_ext;
        w_nxt   = w_r + owd_pkg::PW'(pw_r);
        idx_nxt = idx_r + owd_pkg::NW'(1);
      end
      owd_pkg::S_CHK: begin
        res_nxt = aq_trunc[owd_pkg::SMP_W-1:0];
        w_nxt   = w_r << (owd_pkg::SMP_W - 1);
        q_nxt   = '0;
        cnt_nxt = '0;
      end
      owd_pkg::S_QD: begin
        if (q_ge) begin
          p_nxt = p_r - $signed(w_r);
        end
        q_nxt   = {q_r[owd_pkg::SMP_W-2:0], q_ge};
        w_nxt   = w_r >> 1;
        cnt_nxt = cnt_r + owd_pkg::CNT_W'(1);
        if (cnt_r == owd_pkg::CNT_W'(owd_pkg::SMP_W - 1)) begin
          res_nxt = q_nxt;
        end
      end
      owd_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase

    // A new factor discards the partly filled block.
    if (cfg_we) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= owd_pkg::S_IDLE;
      cfg_r       <= owd_pkg::CFG_RESET;
      fill_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    dd_r       <= dd_nxt;
    rem_r      <= rem_nxt;
    aq_r       <= aq_nxt;
    x_r        <= x_nxt;
    d1_r       <= d1_nxt;
    d2_r       <= d2_nxt;
    pm_r       <= pm_nxt;
    pp_r       <= pp_nxt;
    pw_r       <= pw_nxt;
    p_r        <= p_nxt;
    w_r        <= w_nxt;
    q_r        <= q_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> tb/outlier_weighted_decimator_tb.sv
`timescale 1ns / 1ps

module outlier_weighted_decimator_tb;

  localparam int WRITE_SETTLE = 100;
  localparam int DRAIN_WAIT   = 200;

  typedef enum int {
    MATCHED,
    MISMATCHED,
    UNEXPECTED
  } verdict_t;

  // Tracks the partly filled block and predicts the weighted mean of each completed one.
  class block_scoreboard;
    logic signed [owd_pkg::SMP_W-1:0] block_mem[owd_pkg::MAX_FACTOR];
    int                               fill;
    longint                           running_sum;
    int                               factor;
    logic signed [owd_pkg::SMP_W-1:0] mean_q[$];

    function new();
      factor      = int'(owd_pkg::CFG_RESET);
      fill        = 0;
      running_sum = 0;
    endfunction

    function void configure(int value);
      factor      = value;
      fill        = 0;
      running_sum = 0;
    endfunction

    function logic signed [owd_pkg::SMP_W-1:0] weighted_mean(int n);
      longint              aq;
      longint              xi;
      longint              d1;
      longint              d2;
      logic signed [191:0] num;
      logic signed [191:0] den;
      logic signed [191:0] wt;
      aq  = (running_sum * 65536) / n;
      num = 192'(aq) * 65536;
      den = '0;
      den[32] = 1'b1;
      for (int i = 0; i < n; i++) begin
        xi = block_mem[i];
        d1 = xi * 65536 - aq;
        if (d1 < 0) d1 = -d1;
        d2 = d1 - aq;
        if (d2 < 0) d2 = -d2;
        wt  = 192'(d2) * 192'(d2);
        den = den + wt;
        num = num + wt * 192'(xi);
      end
      // A numerator below the small threshold falls back to the plain mean.
      if (num < 42950) return owd_pkg::SMP_W'(aq / 65536);
      return owd_pkg::SMP_W'(num / den);
    endfunction

    function void note_sample(logic signed [owd_pkg::SMP_W-1:0] x);
      int n;
      n = (factor < 1) ? 1 :
          ((factor > owd_pkg::MAX_FACTOR) ? owd_pkg::MAX_FACTOR : factor);
      block_mem[fill] = x;
      running_sum     = running_sum + x;
      fill++;
      if (fill >= n) begin
        mean_q.push_back(weighted_mean(n));
        fill        = 0;
        running_sum = 0;
      end
    endfunction

    function verdict_t check_result(logic signed [owd_pkg::SMP_W-1:0] got,
                                    output logic signed [owd_pkg::SMP_W-1:0] want);
      want = 'x;
      if (mean_q.size() == 0) return UNEXPECTED;
      want = mean_q.pop_front();
      return (got === want) ? MATCHED : MISMATCHED;
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [owd_pkg::CFG_W-1:0]     cfg_wdata;

  owd_in_if  in_if ();
  owd_out_if out_if ();

  outlier_weighted_decimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  block_scoreboard mean_board;
  int  error_count;
  int  samples_taken;
  int  results_seen;
  int  settings_used;
  bit  no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d results outstanding", mean_board.mean_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report(string what, logic signed [owd_pkg::SMP_W-1:0] got,
                        logic signed [owd_pkg::SMP_W-1:0] want);
    error_count++;
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Every beat on either channel is seen here, at the rising edge.
  always @(posedge clk) begin
    logic signed [owd_pkg::SMP_W-1:0] want;
    verdict_t                         v;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        mean_board.note_sample(in_if.sample_in);
        samples_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        v = mean_board.check_result(out_if.sample_out, want);
        if (v == UNEXPECTED) report("result with none expected", out_if.sample_out, want);
        else if (v == MISMATCHED) report("sample_out mismatch", out_if.sample_out, want);
      end
    end
  end

  // Result side: ready may be held low for a random stall before each beat, unless no_gaps is set.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_sample(logic signed [owd_pkg::SMP_W-1:0] x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (mean_board.mean_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_factor(logic [owd_pkg::CFG_W-1:0] value);
    wait_for_results();
    repeat (WRITE_SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    mean_board.configure(int'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [owd_pkg::SMP_W-1:0] pick_sample(
      logic signed [owd_pkg::SMP_W-1:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 400)) - 200;
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return base + $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  // About half the samples sit near a base level and the rest are outliers, so the weighting matters.
  task automatic random_phase(int count);
    logic signed [owd_pkg::SMP_W-1:0] base;
    no_gaps = ($urandom_range(0, 3) == 0);
    base    = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) base = $urandom;
      if (i == count / 2) wait_for_results();
      send_sample(pick_sample(base));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [owd_pkg::CFG_W-1:0] fac;
    mean_board      = new();
    error_count     = 0;
    samples_taken   = 0;
    results_seen    = 0;
    settings_used   = 0;
    no_gaps         = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset factor of two: extremes, zeros and a sign flip around zero.
    send_sample(32'sh7FFF_FFFF); send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000); send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF); send_sample(32'sh8000_0000);
    send_sample(32'sd0);         send_sample(32'sd0);
    send_sample(-32'sd1);        send_sample(-32'sd1);
    send_sample(32'sd1);         send_sample(-32'sd1);
    send_sample(32'sd5);         send_sample(32'sd7);
    send_sample(-32'sd1000);     send_sample(32'sd3);

    // A partial block is dropped by a write; zero acts as one.
    send_sample(32'sd12345);
    write_factor(7'd0);
    send_sample(32'sh8000_0000); send_sample(32'sd0); send_sample(32'sh7FFF_FFFF);
    write_factor(7'd127);
    for (int i = 0; i < 64; i++) send_sample(pick_sample(32'sd100));
    write_factor(7'd64);
    for (int i = 0; i < 64; i++) send_sample((i == 5) ? 32'sh7FFF_FFFF : -32'sd40);

    write_factor(7'd1);   random_phase(120);
    write_factor(7'd64);  random_phase(192);
    write_factor(7'd127); random_phase(128);
    write_factor(7'd0);   random_phase(80);
    write_factor(7'd2);   random_phase(300);
    write_factor(7'd3);   random_phase(300);
    for (int k = 0; k < 8; k++) begin
      fac = 7'($urandom_range(4, 12));
      if (k == 3) fac = 7'd32;
      write_factor(fac);
      random_phase(100);
    end

    wait_for_results();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Covered %0d samples and %0d block results over %0d factor settings.",
             samples_taken, results_seen, settings_used);
    if (error_count == 0 && mean_board.mean_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors, %0d results outstanding", error_count, mean_board.mean_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/owd_pkg.sv
rtl/owd_in_if.sv
rtl/owd_out_if.sv
rtl/owd_ram.sv
rtl/outlier_weighted_decimator.sv
tb/outlier_weighted_decimator_tb.sv
